@@ hw/rtl/rita_pkg.sv @@
// Shared constants, types and functions for the radix integer-to-ASCII converter.
package rita_pkg;

    localparam int VALUE_BITS = 32;
    localparam int IDX_BITS   = $clog2(VALUE_BITS);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int RADIX_BITS = 6;
    localparam int CHAR_BITS  = 8;

    localparam logic [RADIX_BITS-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX     = 6'd36;
    localparam logic [RADIX_BITS-1:0] RADIX_RESET   = 6'd10;
    localparam logic [RADIX_BITS-1:0] DECIMAL_LIMIT = 6'd10;
    localparam logic [CHAR_BITS-1:0]  CHAR_ZERO     = 8'h30;
    localparam logic [CHAR_BITS-1:0]  CHAR_LETTER   = 8'h57;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [RADIX_BITS-1:0] t_digit;

    typedef struct packed {
        logic   start;
        t_value dividend;
        t_digit divisor;
    } t_div_req;

    typedef struct packed {
        logic   done;
        t_value quotient;
        t_digit remainder;
    } t_div_rsp;

    function automatic t_digit effective_radix(input t_digit r);
        t_digit res;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end else begin
            res = r;
        end
        return res;
    endfunction

    function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input t_digit d);
        logic [CHAR_BITS-1:0] res;
        if (d < DECIMAL_LIMIT) begin
            res = CHAR_ZERO + {2'b00, d};
        end else begin
            res = CHAR_LETTER + {2'b00, d};
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/rita_divider.sv @@
// Bit-serial restoring divider that yields one quotient bit per cycle.
module rita_divider import rita_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    t_value              r_quo;
    t_digit              r_rem;
    t_digit              r_div;
    logic [IDX_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [RADIX_BITS:0] trial;
    logic                fits;

    assign trial = {r_rem, r_quo[VALUE_BITS-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == IDX_BITS'(VALUE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[VALUE_BITS-2:0], fits};
            if (fits) begin
                r_rem <= RADIX_BITS'(trial - {1'b0, r_div});
            end else begin
                r_rem <= trial[RADIX_BITS-1:0];
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

@@ hw/rtl/rita_digit_store.sv @@
// Digit buffer memory with one write port and one registered read port.
module rita_digit_store import rita_pkg::*; (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [IDX_BITS-1:0] i_waddr,
    input  t_digit              i_wdata,
    input  logic [IDX_BITS-1:0] i_raddr,
    output t_digit              o_rdata
);

    t_digit r_mem [VALUE_BITS];
    t_digit r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/radix_integer_to_ascii.sv @@
// Top level of the radix integer-to-ASCII converter.
// A transaction is accepted at a rising edge with i_start high and o_busy low;
// i_value is then taken and converted in the base held in the radix register.
// The register is written through i_radix_we and i_radix_wdata; the user is to
// write it only while the block is idle, as the block does not enforce this.
// Values below two count as two and above 36 as 36. Each digit is formed by a
// bit-serial divider that takes one quotient bit per cycle, and remainders are
// kept in a small digit buffer.
// The characters then leave most significant first, one per cycle, each on
// o_digit_char for a single cycle marked by o_strobe; o_last_digit marks the
// final character. Zero gives the single character '0'.
// The receiver cannot stall; each character is taken in the cycle it appears.
// Reset is synchronous and active low; it returns the block to idle and sets
// the radix to ten. The next transaction is accepted once o_busy is low.
module radix_integer_to_ascii import rita_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [31:0]           i_value,
    input  logic                  i_radix_we,
    input  logic [RADIX_BITS-1:0] i_radix_wdata,
    output logic                  o_strobe,
    output logic [CHAR_BITS-1:0]  o_digit_char,
    output logic                  o_last_digit
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT,
        S_DRAIN
    } t_state;

    t_state              r_state;
    t_digit              r_radix;
    t_digit              r_base;
    t_value              r_work;
    logic                r_div_start;
    logic [CNT_BITS-1:0] r_count;
    logic [IDX_BITS-1:0] r_idx;
    logic                r_pend;
    logic                r_pend_last;
    logic                r_strobe;
    logic                r_last;
    logic [CHAR_BITS-1:0] r_char;

    t_div_req div_req;
    t_div_rsp div_rsp;
    logic     buf_we;
    t_digit   buf_rdata;

    assign div_req.start    = r_div_start;
    assign div_req.dividend = r_work;
    assign div_req.divisor  = r_base;

    assign buf_we = (r_state == S_DIV) && div_rsp.done;

    rita_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    rita_digit_store u_store (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (r_count[IDX_BITS-1:0]),
        .i_wdata (div_rsp.remainder),
        .i_raddr (r_idx),
        .o_rdata (buf_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_radix_we) begin
            r_radix <= i_radix_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_count     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_strobe    <= 1'b0;
            r_last      <= 1'b0;
            r_char      <= '0;
        end else begin
            r_div_start <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_strobe    <= r_pend;
            r_last      <= r_pend_last;
            r_char      <= digit_to_ascii(buf_rdata);
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_work      <= VALUE_BITS'(i_value);
                        r_base      <= effective_radix(r_radix);
                        r_count     <= '0;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_count <= r_count + 1'b1;
                        if (div_rsp.quotient == '0) begin
                            r_idx   <= r_count[IDX_BITS-1:0];
                            r_state <= S_EMIT;
                        end else begin
                            r_work      <= div_rsp.quotient;
                            r_div_start <= 1'b1;
                        end
                    end
                end
                S_EMIT: begin
                    r_pend      <= 1'b1;
                    r_pend_last <= (r_idx == '0);
                    if (r_idx == '0) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!r_pend) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_digit_char = r_char;
    assign o_last_digit = r_last;

endmodule
